// ===== src/cfrr_pkg.sv =====
package cfrr_pkg;

    // sizes
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int LINKS             = 2;
    localparam int LINK_W            = 1;
    localparam int LANES             = 8;
    localparam int LANE_W            = 3;
    localparam int HDR_BYTES         = 6;
    localparam int IDX_W             = 6;

    // frame delimiters and command bytes
    localparam logic [7:0] SOF_CMD     = 8'h02;
    localparam logic [7:0] SOF_META    = 8'h04;
    localparam logic [7:0] CMD_CRED    = 8'hF9;
    localparam logic [7:0] CMD_STATUS  = 8'hF0;
    localparam logic [7:0] CMD_RLY_ON  = 8'h52;
    localparam logic [7:0] CMD_RLY_OFF = 8'h53;
    localparam logic [7:0] CMD_IGN_LO  = 8'h54;
    localparam logic [7:0] CMD_IGN_HI  = 8'h56;
    localparam logic [7:0] META_PING   = 8'h03;

    // connect status ranges, two code groups of five
    localparam logic [7:0] CS_BASE_A = 8'h0A;
    localparam logic [7:0] CS_BASE_B = 8'h14;
    localparam logic [7:0] CS_SPAN   = 8'd5;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CLEN  = 3'd1;
    localparam logic [2:0] PH_CBODY = 3'd2;
    localparam logic [2:0] PH_MLEN  = 3'd3;
    localparam logic [2:0] PH_MBODY = 3'd4;

    // status codes
    localparam logic [2:0] ST_VALID = 3'd0;
    localparam logic [2:0] ST_OTHER = 3'd5;

    typedef enum logic [3:0] {
        EV_ON        = 4'd0,
        EV_OFF       = 4'd1,
        EV_UNMATCHED = 4'd2,
        EV_CRED      = 4'd3,
        EV_STATUS    = 4'd4,
        EV_PING      = 4'd5,
        EV_IGNORED   = 4'd6,
        EV_UNKNOWN   = 4'd7,
        EV_META      = 4'd8
    } t_event_kind;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  len;
        logic [8:0]  cnt;
        logic [47:0] hdr;
    } t_prs;

    typedef struct packed {
        logic [7:0]  relay;
        logic [7:0]  surface;
        logic [15:0] device;
        logic [7:0]  engine;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             valid;
        t_entry           ent;
    } t_tbl_wr;

    typedef struct packed {
        logic   start;
        t_entry key;
    } t_srch_req;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] line;
    } t_srch_rsp;

    typedef struct packed {
        t_event_kind      kind;
        logic             link;
        logic [IDX_W-1:0] line;
        logic [2:0]       status;
        logic [7:0]       cmd;
    } t_result;

    // connect status byte to status code
    function automatic logic [2:0] map_status(input logic [7:0] code);
        logic [7:0] da;
        logic [7:0] db;
        da = code - CS_BASE_A;
        db = code - CS_BASE_B;
        if (code >= CS_BASE_A && da < CS_SPAN)
            map_status = da[2:0];
        else if (code >= CS_BASE_B && db < CS_SPAN)
            map_status = db[2:0];
        else
            map_status = ST_OTHER;
    endfunction

endpackage

// ===== src/cfrr_relay_search.sv =====
module cfrr_relay_search
    import cfrr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tbl_wr   i_wr,
    input  t_srch_req i_req,
    output t_srch_rsp o_rsp
);

    localparam int ROWS  = (TABLE_ENTRIES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VLD_W = ROW_W + LANE_W;
    localparam int VLD_N = (1 << ROW_W) * LANES;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // table rows of eight entries, valid bits in flops
    t_entry [LANES-1:0] mem [ROWS];
    logic [VLD_N-1:0]   r_vld;

    t_entry [LANES-1:0] r_q;
    t_entry             r_key;
    logic [ROW_W-1:0]   r_row;
    logic               r_busy;

    logic               wr_ok;
    logic [ROW_W-1:0]   wr_row;
    logic [LANE_W-1:0]  wr_lane;
    logic [VLD_W-1:0]   wr_vidx;
    logic [ROW_W-1:0]   rd_row;
    logic               hit;
    logic [LANE_W-1:0]  hit_lane;
    logic [VLD_W-1:0]   hit_idx;
    logic               last;

    // write address split into row and lane
    assign wr_ok   = i_wr.en && (32'(i_wr.idx) < TABLE_ENTRIES);
    assign wr_row  = ROW_W'(32'(i_wr.idx) >> LANE_W);
    assign wr_lane = i_wr.idx[LANE_W-1:0];
    assign wr_vidx = {wr_row, wr_lane};

    // table write port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_row][wr_lane] <= i_wr.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[wr_vidx] <= i_wr.valid;
        end
    end

    // row read, one row a cycle during a scan
    assign last   = (r_row == LAST_ROW);
    assign rd_row = (r_busy && !last) ? r_row + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        r_q <= mem[rd_row];
    end

    // lowest matching lane of the current row
    always_comb begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (r_vld[{r_row, LANE_W'(k)}] && (r_q[k] == r_key)) begin
                hit      = 1'b1;
                hit_lane = LANE_W'(k);
            end
        end
    end

    assign hit_idx    = {r_row, hit_lane};
    assign o_rsp.done = r_busy && (hit || last);
    assign o_rsp.hit  = hit;
    assign o_rsp.line = IDX_W'(32'(hit_idx));

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy) begin
            if (hit || last) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_key <= i_req.key;
        end
    end

endmodule

// ===== src/console_frame_receiver_relay_match_core.sv =====
// channel   dir  tdata (low bit up)                               tuser
// s_axis    in   rx_byte, entry_index, entry_valid, engine_number, opcode, link
//                device_number, surface_number, relay_number
// m_axis    out  line_index, status_code, command_code            event_kind, event_link
//
// a byte that does not end a frame passes S_IDLE and S_EXEC, one that ends a
// non-relay frame also S_EMIT; a relay on/off frame adds S_SCAN, a table scan
// of one 8-entry row per cycle, ending at the first hit or the last row
// table writes are registered; per-link parser state sits in a small memory
// synchronous active-low reset clears parser and table valid bits at once
// a stalled result beat is held in the output register; the next beat is
// taken meanwhile and only waits if it too ends a frame
module console_frame_receiver_relay_match_core
    import cfrr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte[7:0], entry_index[13:8], entry_valid[14], engine_number[22:15],
    // device_number[38:23], surface_number[46:39], relay_number[54:47]
    input  logic [55:0] s_axis_tdata,
    // opcode[0], link[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // line_index[5:0], status_code[8:6], command_code[16:9]
    output logic [23:0] m_axis_tdata,
    // event_kind[3:0], event_link[4]
    output logic [4:0]  m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // input fields
    logic              in_opcode;
    logic [LINK_W-1:0] in_link;
    logic [7:0]        in_byte;
    logic              s_acc;

    assign in_opcode = s_axis_tuser[0];
    assign in_link   = s_axis_tuser[1];
    assign in_byte   = s_axis_tdata[7:0];
    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // table write from the input beat
    t_tbl_wr   tbl_wr;
    t_srch_req srch_req;
    t_srch_rsp srch_rsp;

    assign tbl_wr.en          = s_acc && in_opcode;
    assign tbl_wr.idx         = s_axis_tdata[13:8];
    assign tbl_wr.valid       = s_axis_tdata[14];
    assign tbl_wr.ent.engine  = s_axis_tdata[22:15];
    assign tbl_wr.ent.device  = s_axis_tdata[38:23];
    assign tbl_wr.ent.surface = s_axis_tdata[46:39];
    assign tbl_wr.ent.relay   = s_axis_tdata[54:47];

    cfrr_relay_search #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_search (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (tbl_wr),
        .i_req  (srch_req),
        .o_rsp  (srch_rsp)
    );

    // per-link parser state memory, entry valid bits stand for reset
    t_prs              prs_mem [LINKS];
    logic [LINKS-1:0]  r_prs_vld;
    t_prs              r_prs_q;
    logic              r_prs_q_vld;
    logic [LINK_W-1:0] r_link;
    logic [7:0]        r_byte;
    logic              byte_go;

    assign byte_go = s_acc && !in_opcode && (32'(in_link) < LINKS);

    always_ff @(posedge i_clk) begin
        if (byte_go) begin
            r_prs_q     <= prs_mem[in_link];
            r_prs_q_vld <= r_prs_vld[in_link];
            r_link      <= in_link;
            r_byte      <= in_byte;
        end
    end

    // parser step on the fetched state
    t_prs       cur;
    t_prs       nxt;
    logic       fin;
    logic       meta;
    logic [8:0] cnt_inc;

    assign cur     = r_prs_q_vld ? r_prs_q : '0;
    assign cnt_inc = cur.cnt + 9'd1;

    always_comb begin
        nxt  = cur;
        fin  = 1'b0;
        meta = 1'b0;
        unique case (cur.phase)
            PH_CLEN, PH_MLEN: begin
                meta    = (cur.phase == PH_MLEN);
                nxt.len = r_byte;
                nxt.cnt = '0;
                nxt.hdr = '0;
                if (r_byte == 8'd0) begin
                    fin       = 1'b1;
                    nxt.phase = PH_IDLE;
                end else begin
                    nxt.phase = meta ? PH_MBODY : PH_CBODY;
                end
            end
            PH_CBODY, PH_MBODY: begin
                meta = (cur.phase == PH_MBODY);
                for (int k = 0; k < HDR_BYTES; k++) begin
                    if (cur.cnt == 9'(k)) begin
                        nxt.hdr[k*8 +: 8] = r_byte;
                    end
                end
                nxt.cnt = cnt_inc;
                if (cnt_inc >= {1'b0, cur.len}) begin
                    fin       = 1'b1;
                    nxt.phase = PH_IDLE;
                end
            end
            default: begin
                if (r_byte == SOF_CMD)
                    nxt.phase = PH_CLEN;
                else if (r_byte == SOF_META)
                    nxt.phase = PH_MLEN;
                else
                    nxt.phase = PH_IDLE;
            end
        endcase
    end

    // write back the parser state
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            prs_mem[r_link] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prs_vld <= '0;
        end else if (r_state == S_EXEC) begin
            r_prs_vld[r_link] <= 1'b1;
        end
    end

    // classify the finished frame
    logic [7:0]  h0;
    t_event_kind cls_kind;
    logic [2:0]  cls_status;
    logic        is_relay;

    assign h0 = nxt.hdr[7:0];

    always_comb begin
        cls_status = ST_VALID;
        is_relay   = 1'b0;
        if (meta) begin
            cls_kind = (h0 == META_PING) ? EV_PING : EV_META;
        end else if (h0 == CMD_CRED) begin
            cls_kind = EV_CRED;
        end else if (h0 == CMD_STATUS) begin
            cls_kind   = EV_STATUS;
            cls_status = map_status(nxt.hdr[15:8]);
        end else if (h0 == CMD_RLY_ON || h0 == CMD_RLY_OFF) begin
            cls_kind = EV_UNMATCHED;
            is_relay = 1'b1;
        end else if (h0 >= CMD_IGN_LO && h0 <= CMD_IGN_HI) begin
            cls_kind = EV_IGNORED;
        end else begin
            cls_kind = EV_UNKNOWN;
        end
    end

    // search key from header bytes 1 to 5
    assign srch_req.start       = (r_state == S_EXEC) && fin && is_relay;
    assign srch_req.key.engine  = nxt.hdr[15:8];
    assign srch_req.key.device  = {nxt.hdr[23:16], nxt.hdr[31:24]};
    assign srch_req.key.surface = nxt.hdr[39:32];
    assign srch_req.key.relay   = nxt.hdr[47:40];

    // result staging
    t_result r_res;
    logic    out_free;

    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && fin) begin
            r_res.kind   <= cls_kind;
            r_res.link   <= r_link;
            r_res.line   <= '0;
            r_res.status <= cls_status;
            r_res.cmd    <= h0;
        end else if (r_state == S_SCAN && srch_rsp.done && srch_rsp.hit) begin
            r_res.kind <= (r_res.cmd == CMD_RLY_ON) ? EV_ON : EV_OFF;
            r_res.line <= srch_rsp.line;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (byte_go) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!fin)
                    n_state = S_IDLE;
                else if (is_relay)
                    n_state = S_SCAN;
                else
                    n_state = S_EMIT;
            end
            S_SCAN: begin
                if (srch_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            m_axis_tdata <= {7'd0, r_res.cmd, r_res.status, r_res.line};
            m_axis_tuser <= {r_res.link, r_res.kind};
        end
    end

endmodule
